FILE: src/bearing_inner_angle_unit_defines.svh
// Assertion macros for the checker file of the bearing unit.
`ifndef BEARING_INNER_ANGLE_UNIT_DEFINES_SVH
`define BEARING_INNER_ANGLE_UNIT_DEFINES_SVH

// Condition in a cycle implies a property in the same cycle.
`define BIAU_ASSERT_SAME(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error("bearing unit check failed");

// Condition in a cycle implies a property in the following cycle.
`define BIAU_ASSERT_NEXT(label, cond, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("bearing unit check failed");

`endif

FILE: src/biau_pkg.sv
package biau_pkg;

   // Output angle resolution and CORDIC depth.
   localparam int ANGLE_FRAC_BITS = 28;
   localparam int CORDIC_STAGES   = 24;
   localparam int RND_SH          = 30 - ANGLE_FRAC_BITS;

   // Internal widths.
   localparam int DW = 33;   // coordinate differences
   localparam int CW = 34;   // cosine rotation datapath
   localparam int PW = 64;   // products before normalisation
   localparam int XW = 43;   // vectoring datapath after normalisation
   localparam int ZW = 35;   // accumulated angles, Q30

   localparam logic signed [CW-1:0] COS_HALF_PI  = 34'sd1686629713;
   localparam logic signed [CW-1:0] COS_PI       = 34'sd3373259426;
   localparam logic signed [CW-1:0] COS_INV_GAIN = 34'sd652032874;
   localparam logic signed [CW-1:0] COS_ONE      = 34'sd1073741824;

   localparam logic signed [ZW-1:0] Z_HALF_PI = 35'sd1686629713;
   localparam logic signed [ZW-1:0] Z_PI      = 35'sd3373259426;
   localparam logic signed [ZW-1:0] Z_TWO_PI  = 35'sd6746518852;

   // Degrees times 1e7 to Q62 radians, split into two partial products.
   localparam logic [16:0] DEG_HI = 17'd122816;
   localparam logic [15:0] DEG_LO = 16'd41133;

   typedef struct packed {
      logic signed [DW-1:0] dlat_a;
      logic signed [DW-1:0] dlon_a;
      logic signed [DW-1:0] dlat_b;
      logic signed [DW-1:0] dlon_b;
   } delta_type;

   typedef struct packed {
      logic                 valid;
      logic                 neg;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] th;
      delta_type            d;
   } cos_type;

   typedef struct packed {
      logic                 spec;
      logic signed [ZW-1:0] spec_z;
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
   } lane_type;

   typedef struct packed {
      logic     valid;
      lane_type a;
      lane_type b;
   } vec_type;

   // Floored Q30 arctangent of 2^-k.
   function automatic logic [29:0] atan_q30(input logic [4:0] k);
      logic [29:0] v;
      case (k)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd7;
         5'd28: v = 30'd3;
         5'd29: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

FILE: src/bearing_inner_angle_unit.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | ref_lat, ref_lon, a_lat, a_lon, b_lat, b_lon
// rsp     | out       | rsp_valid/rsp_ready  | bearing_a, bearing_b, inner_angle
// One transaction is accepted per cycle while the output register is free or being emptied.
// A result passes through the cosine and vectoring cell chains plus six further register stages.
// Reset clears only the valid flags of the stages and the output register.
// A stalled output holds the whole pipeline, so req_ready falls with it.
module bearing_inner_angle_unit
   import biau_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [30:0] req_ref_lat,
   input  logic signed [31:0] req_ref_lon,
   input  logic signed [30:0] req_a_lat,
   input  logic signed [31:0] req_a_lon,
   input  logic signed [30:0] req_b_lat,
   input  logic signed [31:0] req_b_lon,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [30:0]        rsp_bearing_a,
   output logic [30:0]        rsp_bearing_b,
   output logic signed [30:0] rsp_inner_angle
);

   logic advance;

   // Stage 1: differences and latitude partial products.
   logic        s1_valid_ff;
   delta_type   s1_d_ff, s1_d_in;
   logic [47:0] s1_pp_hi_ff, s1_pp_hi_in;
   logic [46:0] s1_pp_lo_ff, s1_pp_lo_in;
   logic [30:0] lat_mag;

   // Stage 3: cosine applied to the longitude differences.
   logic                 s3_valid_ff;
   logic signed [PW-1:0] s3_xa_ff, s3_ya_ff, s3_xb_ff, s3_yb_ff;
   logic signed [PW-1:0] s3_xa_in, s3_ya_in, s3_xb_in, s3_yb_in;
   logic signed [DW-1:0] s3_dlat_a_ff, s3_dlat_b_ff;

   // Stage 4: special cases and magnitudes.
   logic                 s4_valid_ff;
   logic signed [PW-1:0] s4_xa_ff, s4_ya_ff, s4_xb_ff, s4_yb_ff;
   logic [PW-2:0]        s4_ma_ff, s4_mb_ff, s4_ma_in, s4_mb_in;
   logic                 s4_spa_ff, s4_spb_ff, s4_spa_in, s4_spb_in;
   logic signed [ZW-1:0] s4_za_ff, s4_zb_ff, s4_za_in, s4_zb_in;

   // Stage 5: normalising shift counts.
   logic                 s5_valid_ff;
   logic signed [PW-1:0] s5_xa_ff, s5_ya_ff, s5_xb_ff, s5_yb_ff;
   logic [4:0]           s5_ra_ff, s5_rb_ff, s5_ra_in, s5_rb_in;
   logic                 s5_spa_ff, s5_spb_ff;
   logic signed [ZW-1:0] s5_za_ff, s5_zb_ff;

   // Stage 7: bearings.
   logic                 s7_valid_ff;
   logic signed [ZW-1:0] s7_ba_ff, s7_bb_ff, s7_ba_in, s7_bb_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [30:0]          rsp_ba_ff, rsp_bb_ff, rsp_ba_in, rsp_bb_in;
   logic [30:0]          rsp_in_ff, rsp_in_in;

   cos_type cos_chain [0:CORDIC_STAGES];
   vec_type vec_chain [0:CORDIC_STAGES];
   cos_type cos_head;
   vec_type vec_head;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Stage 1 logic.
   always_comb begin
      s1_d_in.dlat_a = {{2{req_a_lat[30]}}, req_a_lat} - {{2{req_ref_lat[30]}}, req_ref_lat};
      s1_d_in.dlat_b = {{2{req_b_lat[30]}}, req_b_lat} - {{2{req_ref_lat[30]}}, req_ref_lat};
      s1_d_in.dlon_a = {req_a_lon[31], req_a_lon} - {req_ref_lon[31], req_ref_lon};
      s1_d_in.dlon_b = {req_b_lon[31], req_b_lon} - {req_ref_lon[31], req_ref_lon};
      lat_mag        = req_ref_lat[30] ? (~req_ref_lat + 31'd1) : req_ref_lat;
      s1_pp_hi_in    = 48'(lat_mag) * 48'(DEG_HI);
      s1_pp_lo_in    = 47'(lat_mag) * 47'(DEG_LO);
   end

   // Stage 2 logic: angle in Q30 and fold into the first quadrant.
   logic [63:0]          th_sum;
   logic signed [CW-1:0] th_raw;
   always_comb begin
      th_sum         = {s1_pp_hi_ff, 16'b0} + 64'(s1_pp_lo_ff) + 64'h8000_0000;
      th_raw         = signed'({2'b00, th_sum[63:32]});
      cos_head.valid = s1_valid_ff;
      cos_head.d     = s1_d_ff;
      cos_head.x     = COS_INV_GAIN;
      cos_head.y     = '0;
      if (th_raw > COS_HALF_PI) begin
         cos_head.th  = COS_PI - th_raw;
         cos_head.neg = 1'b1;
      end else begin
         cos_head.th  = th_raw;
         cos_head.neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_d_ff     <= s1_d_in;
         s1_pp_hi_ff <= s1_pp_hi_in;
         s1_pp_lo_ff <= s1_pp_lo_in;
      end
   end

   // Cosine rotation chain.
   assign cos_chain[0] = cos_head;
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cos
      biau_cos_stage u_cos (
         .clock (clock),
         .reset (reset),
         .en    (advance),
         .idx   (5'(g)),
         .d_in  (cos_chain[g]),
         .q_out (cos_chain[g+1])
      );
   end

   // Stage 3 logic: clamp the cosine and scale the longitude differences.
   cos_type              cos_tail;
   logic signed [CW-1:0] cx;
   logic signed [31:0]   cosv;
   logic signed [PW:0]   prod_a, prod_b;
   always_comb begin
      cos_tail = cos_chain[CORDIC_STAGES];
      cx       = cos_tail.x;
      if (cx < 0) begin
         cx = '0;
      end else if (cx > COS_ONE) begin
         cx = COS_ONE;
      end
      cosv     = cos_tail.neg ? -cx[31:0] : cx[31:0];
      prod_a   = cos_tail.d.dlon_a * cosv;
      prod_b   = cos_tail.d.dlon_b * cosv;
      s3_xa_in = prod_a[PW-1:0];
      s3_xb_in = prod_b[PW-1:0];
      s3_ya_in = {{(PW-DW-30){cos_tail.d.dlat_a[DW-1]}}, cos_tail.d.dlat_a, 30'b0};
      s3_yb_in = {{(PW-DW-30){cos_tail.d.dlat_b[DW-1]}}, cos_tail.d.dlat_b, 30'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= cos_tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_xa_ff     <= s3_xa_in;
         s3_ya_ff     <= s3_ya_in;
         s3_xb_ff     <= s3_xb_in;
         s3_yb_ff     <= s3_yb_in;
         s3_dlat_a_ff <= cos_tail.d.dlat_a;
         s3_dlat_b_ff <= cos_tail.d.dlat_b;
      end
   end

   // Stage 4 logic: axis cases and the larger magnitude of each pair.
   function automatic logic [PW-2:0] mag64(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = (v < 0) ? -v : v;
      return t[PW-2:0];
   endfunction

   function automatic logic signed [ZW-1:0] axis_z(input logic signed [DW-1:0] dl,
                                                   input logic signed [PW-1:0] p);
      logic signed [ZW-1:0] z;
      if (dl == 0) begin
         z = (p < 0) ? Z_PI : '0;
      end else begin
         z = (dl > 0) ? Z_HALF_PI : -Z_HALF_PI;
      end
      return z;
   endfunction

   logic [PW-2:0] mxa, mya, mxb, myb;
   always_comb begin
      mxa       = mag64(s3_xa_ff);
      mya       = mag64(s3_ya_ff);
      mxb       = mag64(s3_xb_ff);
      myb       = mag64(s3_yb_ff);
      s4_ma_in  = (mxa > mya) ? mxa : mya;
      s4_mb_in  = (mxb > myb) ? mxb : myb;
      s4_spa_in = (s3_dlat_a_ff == 0) || (s3_xa_ff == 0);
      s4_spb_in = (s3_dlat_b_ff == 0) || (s3_xb_ff == 0);
      s4_za_in  = axis_z(s3_dlat_a_ff, s3_xa_ff);
      s4_zb_in  = axis_z(s3_dlat_b_ff, s3_xb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_xa_ff  <= s3_xa_ff;
         s4_ya_ff  <= s3_ya_ff;
         s4_xb_ff  <= s3_xb_ff;
         s4_yb_ff  <= s3_yb_ff;
         s4_ma_ff  <= s4_ma_in;
         s4_mb_ff  <= s4_mb_in;
         s4_spa_ff <= s4_spa_in;
         s4_spb_ff <= s4_spb_in;
         s4_za_ff  <= s4_za_in;
         s4_zb_ff  <= s4_zb_in;
      end
   end

   // Stage 5 logic: shift count that brings the magnitude below 2^40.
   function automatic logic [4:0] norm_shift(input logic [PW-2:0] m);
      logic [4:0] r;
      r = '0;
      for (int i = 0; i < PW - 41; i++) begin
         if (m[40+i]) begin
            r = 5'(i + 1);
         end
      end
      return r;
   endfunction

   assign s5_ra_in = norm_shift(s4_ma_ff);
   assign s5_rb_in = norm_shift(s4_mb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s5_xa_ff  <= s4_xa_ff;
         s5_ya_ff  <= s4_ya_ff;
         s5_xb_ff  <= s4_xb_ff;
         s5_yb_ff  <= s4_yb_ff;
         s5_ra_ff  <= s5_ra_in;
         s5_rb_ff  <= s5_rb_in;
         s5_spa_ff <= s4_spa_ff;
         s5_spb_ff <= s4_spb_ff;
         s5_za_ff  <= s4_za_ff;
         s5_zb_ff  <= s4_zb_ff;
      end
   end

   // Stage 6 logic: normalise and fold the left half plane.
   function automatic lane_type lane_init(input logic signed [PW-1:0] x,
                                          input logic signed [PW-1:0] y,
                                          input logic [4:0] r,
                                          input logic sp,
                                          input logic signed [ZW-1:0] sz);
      lane_type             l;
      logic signed [PW-1:0] xs, ys;
      xs       = x >>> r;
      ys       = y >>> r;
      l.spec   = sp;
      l.spec_z = sz;
      if (xs < 0) begin
         l.z = (ys >= 0) ? Z_PI : -Z_PI;
         xs  = -xs;
         ys  = -ys;
      end else begin
         l.z = '0;
      end
      l.x = xs[XW-1:0];
      l.y = ys[XW-1:0];
      return l;
   endfunction

   always_comb begin
      vec_head.valid = s5_valid_ff;
      vec_head.a     = lane_init(s5_xa_ff, s5_ya_ff, s5_ra_ff, s5_spa_ff, s5_za_ff);
      vec_head.b     = lane_init(s5_xb_ff, s5_yb_ff, s5_rb_ff, s5_spb_ff, s5_zb_ff);
   end

   // Vectoring chain.
   assign vec_chain[0] = vec_head;
   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
      biau_vec_stage u_vec (
         .clock (clock),
         .reset (reset),
         .en    (advance),
         .idx   (5'(g)),
         .d_in  (vec_chain[g]),
         .q_out (vec_chain[g+1])
      );
   end

   // Stage 7 logic: clamp the angle and turn it into a compass bearing.
   function automatic logic signed [ZW-1:0] to_bearing(input lane_type l);
      logic signed [ZW-1:0] z, b;
      z = l.z;
      if (z > Z_PI) begin
         z = Z_PI;
      end else if (z < -Z_PI) begin
         z = -Z_PI;
      end
      if (l.spec) begin
         z = l.spec_z;
      end
      b = Z_HALF_PI - z;
      if (b < 0) begin
         b = b + Z_TWO_PI;
      end
      return b;
   endfunction

   vec_type vec_tail;
   always_comb begin
      vec_tail = vec_chain[CORDIC_STAGES];
      s7_ba_in = to_bearing(vec_tail.a);
      s7_bb_in = to_bearing(vec_tail.b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else if (advance) begin
         s7_valid_ff <= vec_tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s7_ba_ff <= s7_ba_in;
         s7_bb_ff <= s7_bb_in;
      end
   end

   // Output stage: wrapped difference and rounding to the output scale.
   function automatic logic [30:0] round_out(input logic signed [ZW-1:0] v);
      logic signed [ZW-1:0] t;
      t = (v + ZW'(1 << (RND_SH - 1))) >>> RND_SH;
      return t[30:0];
   endfunction

   logic signed [ZW-1:0] diff;
   always_comb begin
      diff = s7_ba_ff - s7_bb_ff;
      if (diff > Z_PI) begin
         diff = diff - Z_TWO_PI;
      end else if (diff < -Z_PI) begin
         diff = diff + Z_TWO_PI;
      end
      rsp_ba_in    = round_out(s7_ba_ff);
      rsp_bb_in    = round_out(s7_bb_ff);
      rsp_in_in    = round_out(diff);
      rsp_valid_in = advance ? s7_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ba_ff <= rsp_ba_in;
         rsp_bb_ff <= rsp_bb_in;
         rsp_in_ff <= rsp_in_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_bearing_a   = rsp_ba_ff;
   assign rsp_bearing_b   = rsp_bb_ff;
   assign rsp_inner_angle = signed'(rsp_in_ff);

endmodule

FILE: src/biau_cos_stage.sv
module biau_cos_stage
   import biau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic [4:0] idx,
   input  cos_type    d_in,
   output cos_type    q_out
);

   cos_type              q_ff, q_in;
   logic signed [CW-1:0] xs, ys, dx, dy, at;

   // One rotation step towards the residual angle.
   always_comb begin
      xs   = d_in.x;
      ys   = d_in.y;
      dx   = ys >>> idx;
      dy   = xs >>> idx;
      at   = signed'({{(CW-30){1'b0}}, atan_q30(idx)});
      q_in = d_in;
      if (d_in.th >= 0) begin
         q_in.x  = xs - dx;
         q_in.y  = ys + dy;
         q_in.th = d_in.th - at;
      end else begin
         q_in.x  = xs + dx;
         q_in.y  = ys - dy;
         q_in.th = d_in.th + at;
      end
   end

   // Stage register; only the valid flag is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign q_out = q_ff;

endmodule

FILE: src/biau_vec_stage.sv
module biau_vec_stage
   import biau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic [4:0] idx,
   input  vec_type    d_in,
   output vec_type    q_out
);

   vec_type q_ff, q_in;

   // One vectoring step driving y towards zero.
   function automatic lane_type step(input lane_type l, input logic [4:0] k);
      lane_type             r;
      logic signed [XW-1:0] xs, ys, dx, dy;
      logic signed [ZW-1:0] at;
      r  = l;
      xs = l.x;
      ys = l.y;
      dx = ys >>> k;
      dy = xs >>> k;
      at = signed'({{(ZW-30){1'b0}}, atan_q30(k)});
      if (ys >= 0) begin
         r.x = xs + dx;
         r.y = ys - dy;
         r.z = l.z + at;
      end else begin
         r.x = xs - dx;
         r.y = ys + dy;
         r.z = l.z - at;
      end
      return r;
   endfunction

   always_comb begin
      q_in       = d_in;
      q_in.a     = step(d_in.a, idx);
      q_in.b     = step(d_in.b, idx);
   end

   // Stage register; only the valid flag is reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (en) begin
         q_ff <= q_in;
      end
   end

   assign q_out = q_ff;

endmodule

FILE: src/biau_checker.sv
`include "bearing_inner_angle_unit_defines.svh"

module biau_checker
   import biau_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [30:0]        rsp_bearing_a,
   input logic [30:0]        rsp_bearing_b,
   input logic signed [30:0] rsp_inner_angle
);

   // A waiting result transaction is held until it is taken.
   `BIAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // The unit only stalls its input while a result is waiting.
   `BIAU_ASSERT_SAME(a_req_free, !rsp_valid || rsp_ready, req_ready)

   // Bearings stay within one full turn.
   `BIAU_ASSERT_SAME(a_bearing_range, rsp_valid,
      (rsp_bearing_a <= 31'd1686629713) && (rsp_bearing_b <= 31'd1686629713))

   // The inner angle stays within a half turn either way.
   `BIAU_ASSERT_SAME(a_inner_range, rsp_valid,
      (rsp_inner_angle <= 31'sd843314857) && (rsp_inner_angle >= -31'sd843314857))

endmodule

bind bearing_inner_angle_unit biau_checker u_biau_checker (.*);
